@@ src/jse_pkg.sv @@
package jse_pkg;

  // Default longest UTF-8 sequence that is gathered and decoded
  localparam int MAX_SEQ_BYTES_DEF = 8;

  // Depth of the command queue between front and back
  localparam int Q_DEPTH = 4;

  // ASCII characters used by the escape forms
  localparam logic [6:0] CH_BSLASH = 7'h5c;
  localparam logic [6:0] CH_U      = 7'h75;

  // One code point to emit, as queued from front to back
  typedef struct packed {
    logic [31:0] code;
    logic        last;   // last code caused by its input request
    logic        done;   // last code of the whole string
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_FLUSH,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    M_LIT,
    M_SHORT,
    M_HEX
  } esc_mode_t;

  // Sequence length (2..6) of a lead byte 0xC0..0xFF
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[5]) len = 3'd2;
    else if (!b[4]) len = 3'd3;
    else if (!b[3]) len = 3'd4;
    else if (!b[2]) len = 3'd5;
    else len = 3'd6;
    return len;
  endfunction

  // Payload bits kept from the lead byte
  function automatic logic [7:0] lead_mask(input logic [2:0] len);
    logic [7:0] m;
    case (len)
      3'd2:    m = 8'h1f;
      3'd3:    m = 8'h0f;
      3'd4:    m = 8'h07;
      default: m = 8'h03;
    endcase
    return m;
  endfunction

  // How a code point is written out
  function automatic esc_mode_t esc_mode(input logic [31:0] c);
    esc_mode_t m;
    if (c[31:7] != '0) begin
      m = M_HEX;
    end else begin
      case (c[6:0]) inside
        7'd9, 7'd10, 7'd12, 7'd13, 7'd34, 7'd47, 7'd92: m = M_SHORT;
        [7'd0:7'd31], 7'd38, 7'd39, [7'd60:7'd62], 7'd127: m = M_HEX;
        default: m = M_LIT;
      endcase
    end
    return m;
  endfunction

  // Second character of a two-character escape
  function automatic logic [6:0] short_char(input logic [6:0] c);
    logic [6:0] ch;
    case (c)
      7'd9:    ch = 7'h74;  // t
      7'd10:   ch = 7'h6e;  // n
      7'd12:   ch = 7'h66;  // f
      7'd13:   ch = 7'h72;  // r
      7'd34:   ch = 7'h22;  // "
      7'd47:   ch = 7'h2f;  // /
      default: ch = 7'h5c;  // backslash
    endcase
    return ch;
  endfunction

  // Lowercase hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] ch;
    if (n < 4'd10) ch = {3'b011, n};
    else ch = 7'h57 + {3'b000, n};
    return ch;
  endfunction

  // UTF-16 form: low half first unit, high half second unit (zero if none)
  function automatic logic [31:0] to_utf16(input logic [31:0] x);
    logic [31:0] w;
    logic [31:0] v;
    v = x - 32'h0001_0000;
    if (x <= 32'h0000_d7ff || (x >= 32'h0000_e000 && x <= 32'h0000_ffff)) begin
      w = x;
    end else if (x >= 32'h0001_0000 && x <= 32'h0010_ffff) begin
      w = {6'b110111, v[9:0], 6'b110110, v[19:10]};
    end else begin
      w = 32'h0000_fffd;
    end
    return w;
  endfunction

endpackage

@@ src/jse_front.sv @@
module jse_front
  import jse_pkg::*;
#(
  parameter int MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  input  logic       push,
  output logic       full,
  output cmd_t       q_data,
  output logic       q_push,
  input  logic       q_full
);

  localparam int HELD_DEPTH = MAX_SEQ_BYTES - 1;
  localparam int CNT_W      = $clog2(MAX_SEQ_BYTES);
  localparam int HIDX_W     = $clog2(HELD_DEPTH);
  localparam logic [3:0] MAX_LEN = 4'(MAX_SEQ_BYTES);

  front_state_t state, state_next;
  logic [7:0]       lead_byte, lead_byte_next;
  logic [2:0]       needed, needed_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic [31:0]      acc, acc_next;
  logic [7:0]       held_bytes [HELD_DEPTH];
  logic [7:0]       b_reg, b_reg_next;
  logic             eos_reg, eos_reg_next;
  logic             fresh_after, fresh_after_next;
  logic [CNT_W-1:0] flush_idx, flush_idx_next;
  logic [31:0]      code_reg, code_reg_next;

  logic             held_we;
  logic             cont;
  logic [31:0]      acc_shift;
  logic [CNT_W:0]   count_inc;
  logic             completes;
  logic             in_starts;
  logic             b_starts;
  logic [CNT_W-1:0] flush_m1;
  logic [7:0]       flush_byte;
  logic             flush_final;
  logic             flush_last;

  // Lead byte that opens a sequence short enough to gather
  function automatic logic fresh_start(input logic [7:0] b, input logic eos);
    return (b[7:6] == 2'b11) && !eos && ({1'b0, seq_len(b)} <= MAX_LEN);
  endfunction

  // Classification of the incoming and the held byte
  assign cont      = (in_byte[7:6] == 2'b10);
  assign acc_shift = {acc[25:0], in_byte[5:0]};
  assign count_inc = {1'b0, held_count} + (CNT_W + 1)'(1);
  assign completes = (4'(count_inc) >= {1'b0, needed});
  assign in_starts = fresh_start(in_byte, end_of_string);
  assign b_starts  = fresh_start(b_reg, eos_reg);

  // Flush walks the lead byte, then each held byte
  assign flush_m1    = flush_idx - CNT_W'(1);
  assign flush_byte  = (flush_idx == '0) ? lead_byte : held_bytes[flush_m1[HIDX_W-1:0]];
  assign flush_final = (flush_idx == held_count);
  assign flush_last  = flush_final && (!fresh_after || b_starts);

  always_comb begin
    state_next       = state;
    lead_byte_next   = lead_byte;
    needed_next      = needed;
    held_count_next  = held_count;
    acc_next         = acc;
    b_reg_next       = b_reg;
    eos_reg_next     = eos_reg;
    fresh_after_next = fresh_after;
    flush_idx_next   = flush_idx;
    code_reg_next    = code_reg;
    held_we          = 1'b0;
    q_push           = 1'b0;
    q_data           = '{code: code_reg, last: 1'b1, done: eos_reg};
    full             = (state != F_IDLE);

    case (state)
      F_IDLE: begin
        if (push) begin
          b_reg_next     = in_byte;
          eos_reg_next   = end_of_string;
          flush_idx_next = '0;
          if (needed != 3'd0 && cont) begin
            // continuation of the pending sequence
            acc_next = acc_shift;
            if (completes) begin
              code_reg_next   = acc_shift;
              state_next      = F_PUSH;
              lead_byte_next  = '0;
              needed_next     = '0;
              held_count_next = '0;
              acc_next        = '0;
            end else begin
              held_we         = 1'b1;
              held_count_next = count_inc[CNT_W-1:0];
              if (end_of_string) begin
                state_next       = F_FLUSH;
                fresh_after_next = 1'b0;
              end
            end
          end else if (needed != 3'd0) begin
            // broken sequence: flush, then handle this byte afresh
            state_next       = F_FLUSH;
            fresh_after_next = 1'b1;
          end else if (in_starts) begin
            lead_byte_next  = in_byte;
            needed_next     = seq_len(in_byte) - 3'd1;
            held_count_next = '0;
            acc_next        = {24'b0, in_byte & lead_mask(seq_len(in_byte))};
          end else begin
            code_reg_next = {24'b0, in_byte};
            state_next    = F_PUSH;
          end
        end
      end

      F_FLUSH: begin
        q_data = '{code: {24'b0, flush_byte}, last: flush_last,
                   done: flush_last && eos_reg};
        if (!q_full) begin
          q_push = 1'b1;
          if (flush_final) begin
            lead_byte_next  = '0;
            needed_next     = '0;
            held_count_next = '0;
            acc_next        = '0;
            if (fresh_after && b_starts) begin
              lead_byte_next = b_reg;
              needed_next    = seq_len(b_reg) - 3'd1;
              acc_next       = {24'b0, b_reg & lead_mask(seq_len(b_reg))};
              state_next     = F_IDLE;
            end else if (fresh_after) begin
              code_reg_next = {24'b0, b_reg};
              state_next    = F_PUSH;
            end else begin
              state_next = F_IDLE;
            end
          end else begin
            flush_idx_next = flush_idx + CNT_W'(1);
          end
        end
      end

      F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end

      default: state_next = F_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      needed     <= '0;
      held_count <= '0;
      lead_byte  <= '0;
      acc        <= '0;
    end else begin
      state      <= state_next;
      needed     <= needed_next;
      held_count <= held_count_next;
      lead_byte  <= lead_byte_next;
      acc        <= acc_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    b_reg       <= b_reg_next;
    eos_reg     <= eos_reg_next;
    fresh_after <= fresh_after_next;
    flush_idx   <= flush_idx_next;
    code_reg    <= code_reg_next;
  end

  // Held continuation bytes
  always_ff @(posedge clk) begin
    if (held_we) begin
      held_bytes[held_count[HIDX_W-1:0]] <= in_byte;
    end
  end

`ifndef SYNTHESIS
  a_flush_in_range: assert property (@(posedge clk) disable iff (rst)
    state == F_FLUSH |-> flush_idx <= held_count)
    else $error("flush index past held bytes");

  a_held_below_needed: assert property (@(posedge clk) disable iff (rst)
    needed != 3'd0 |-> 4'(held_count) < {1'b0, needed})
    else $error("held count reached needed continuations");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    q_push && q_data.done |=> needed == 3'd0 && state == F_IDLE)
    else $error("sequence still pending after end of string");
`endif

endmodule

@@ src/jse_fifo.sv @@
module jse_fifo
  import jse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  cmd_t           mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PTR_W + 1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) count <= count + (PTR_W + 1)'(1);
      else if (do_pop && !do_push) count <= count - (PTR_W + 1)'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W + 1)'(Q_DEPTH))
    else $error("queue fill count overflow");
`endif

endmodule

@@ src/jse_back.sv @@
module jse_back
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       q_data,
  input  logic       q_empty,
  output logic       q_pop,
  output logic [6:0] out_byte,
  output logic       run_last,
  output logic       string_done,
  output logic       empty,
  input  logic       pop
);

  logic       active, active_next;
  esc_mode_t  mode, mode_next;
  logic [31:0] w, w_next;
  logic [2:0] sub, sub_next;
  logic       half, half_next;
  logic       last_r, last_r_next;
  logic       done_r, done_r_next;
  logic       out_valid, out_valid_next;
  logic [6:0] out_byte_next;
  logic       run_last_next;
  logic       string_done_next;

  logic [6:0]  ch;
  logic        fin;
  logic [15:0] unit;
  logic        advance;
  esc_mode_t   load_mode;

  assign empty     = !out_valid;
  assign load_mode = esc_mode(q_data.code);
  assign unit      = half ? w[31:16] : w[15:0];
  assign advance   = active && (!out_valid || pop);

  // Character at the current position of the escape form
  always_comb begin
    ch  = w[6:0];
    fin = 1'b1;
    case (mode)
      M_LIT: begin
        ch  = w[6:0];
        fin = 1'b1;
      end
      M_SHORT: begin
        ch  = (sub == 3'd0) ? CH_BSLASH : short_char(w[6:0]);
        fin = (sub == 3'd1);
      end
      M_HEX: begin
        case (sub)
          3'd0:    ch = CH_BSLASH;
          3'd1:    ch = CH_U;
          3'd2:    ch = hex_char(unit[15:12]);
          3'd3:    ch = hex_char(unit[11:8]);
          3'd4:    ch = hex_char(unit[7:4]);
          default: ch = hex_char(unit[3:0]);
        endcase
        fin = (sub == 3'd5) && (half || w[31:16] == '0);
      end
      default: begin
        ch  = w[6:0];
        fin = 1'b1;
      end
    endcase
  end

  // Load a command, then step through its characters
  always_comb begin
    active_next      = active;
    mode_next        = mode;
    w_next           = w;
    sub_next         = sub;
    half_next        = half;
    last_r_next      = last_r;
    done_r_next      = done_r;
    out_valid_next   = out_valid;
    out_byte_next    = out_byte;
    run_last_next    = run_last;
    string_done_next = string_done;
    q_pop            = 1'b0;

    if (!active && !q_empty) begin
      q_pop       = 1'b1;
      active_next = 1'b1;
      mode_next   = load_mode;
      w_next      = (load_mode == M_HEX) ? to_utf16(q_data.code) : q_data.code;
      sub_next    = '0;
      half_next   = 1'b0;
      last_r_next = q_data.last;
      done_r_next = q_data.done;
    end

    if (advance) begin
      out_valid_next   = 1'b1;
      out_byte_next    = ch;
      run_last_next    = fin && last_r;
      string_done_next = fin && last_r && done_r;
      if (fin) begin
        active_next = 1'b0;
      end else if (mode == M_HEX && sub == 3'd5) begin
        sub_next  = '0;
        half_next = 1'b1;
      end else begin
        sub_next = sub + 3'd1;
      end
    end else if (pop) begin
      out_valid_next = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      active    <= active_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode        <= mode_next;
    w           <= w_next;
    sub         <= sub_next;
    half        <= half_next;
    last_r      <= last_r_next;
    done_r      <= done_r_next;
    out_byte    <= out_byte_next;
    run_last    <= run_last_next;
    string_done <= string_done_next;
  end

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> run_last)
    else $error("end of string not on last byte of its request");

  a_short_len: assert property (@(posedge clk) disable iff (rst)
    active && mode == M_SHORT |-> sub <= 3'd1)
    else $error("two-character escape ran long");
`endif

endmodule

@@ src/json_string_escaper.sv @@
// Channel   Handshake          Payload
// input     push / full        in_byte[7:0], end_of_string
// output    pop / empty        out_byte[6:0], run_last, string_done
//
// The front accepts a byte that is written as itself, then queues it; the back
// loads a code point, then writes one output character per cycle while the
// output is popped (1, 2, 6 or 12 per code point), so they set sustained rate.
// Broken or cut-short sequences re-emit one byte per cycle unless the queue is full.
// Reset (rst, synchronous) clears control state; held bytes are not cleared.
// Either side may stall; the 4-entry code queue decouples front from back.
module json_string_escaper
  import jse_pkg::*;
#(
  parameter int MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  input  logic       push,
  output logic       full,
  output logic [6:0] out_byte,
  output logic       run_last,
  output logic       string_done,
  output logic       empty,
  input  logic       pop
);

  cmd_t f_data;
  logic f_push;
  logic f_full;
  cmd_t b_data;
  logic b_empty;
  logic b_pop;

  // Decoder and sequence tracker
  jse_front #(
    .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .push         (push),
    .full         (full),
    .q_data       (f_data),
    .q_push       (f_push),
    .q_full       (f_full)
  );

  // Code point queue
  jse_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .wdata(f_data),
    .full (f_full),
    .pop  (b_pop),
    .rdata(b_data),
    .empty(b_empty)
  );

  // Escape writer
  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (b_data),
    .q_empty    (b_empty),
    .q_pop      (b_pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_done(string_done),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
